[sv/jfq_pkg.sv]
// ----------------------------------------------------------------------------
// Joint feedback qualifier package
// Shared types, register map, status codes and joint limit tables.
// ----------------------------------------------------------------------------
package jfq_pkg;

    localparam int NUM_JOINTS  = 5;
    localparam int NUM_OFFSETS = 5;
    localparam int Q_W         = 20;
    localparam int JOINT_W     = 3;
    localparam int AGE_W       = 20;
    localparam int OFF_W       = 14;
    localparam int THR_W       = 19;
    localparam int MASK_W      = 5;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic signed [Q_W-1:0] Q_MAX     = 20'sd524287;
    localparam logic signed [Q_W-1:0] Q_MIN     = -20'sd524288;
    localparam logic signed [Q_W-1:0] FULL_TURN = 20'sd25736;
    localparam logic signed [Q_W-1:0] J1_LOW    = 20'sd0;
    localparam logic signed [Q_W-1:0] J1_HIGH   = 20'sd14336;
    localparam logic [AGE_W-1:0]      MIN_STALE = 20'd10000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_STALE     = 2'd1;
    localparam logic [1:0] ST_NONFINITE = 2'd2;
    localparam logic [1:0] ST_JUMP      = 2'd3;

    localparam logic [2:0] REG_INVERT   = 3'd0;
    localparam logic [2:0] REG_JUMP_THR = 3'd1;
    localparam logic [2:0] REG_STALE    = 3'd2;
    localparam logic [2:0] REG_OFF_A    = 3'd3;
    localparam logic [2:0] REG_OFF_B    = 3'd4;
    localparam logic [2:0] REG_OFF_C    = 3'd5;
    localparam logic [2:0] REG_OFF_D    = 3'd6;
    localparam logic [2:0] REG_OFF_E    = 3'd7;

    localparam logic [JOINT_W-1:0] BIAS_JOINT = 3'd1;

    localparam logic [MASK_W-1:0] RST_INVERT = 5'd0;
    localparam logic [THR_W-1:0]  RST_THR    = 19'd123;
    localparam logic [AGE_W-1:0]  RST_STALE  = 20'd50000;
    localparam logic [OFF_W-1:0]  RST_OFF_A  = -14'sd82;
    localparam logic [OFF_W-1:0]  RST_OFF_B  = 14'sd573;
    localparam logic [OFF_W-1:0]  RST_OFF_C  = 14'sd410;
    localparam logic [OFF_W-1:0]  RST_OFF_D  = 14'sd1479;
    localparam logic [OFF_W-1:0]  RST_OFF_E  = 14'sd0;

    typedef struct packed {
        logic [JOINT_W-1:0]     joint;
        logic                   has_sample;
        logic [AGE_W-1:0]       age_us;
        logic                   sample_finite;
        logic signed [Q_W-1:0]  raw_position;
        logic signed [Q_W-1:0]  raw_velocity;
        logic signed [Q_W-1:0]  raw_torque;
    } t_in;

    typedef struct packed {
        logic signed [Q_W-1:0]  position;
        logic signed [Q_W-1:0]  velocity;
        logic signed [Q_W-1:0]  torque;
        logic                   valid_res;
        logic [1:0]             status;
    } t_out;

    typedef struct packed {
        logic [MASK_W-1:0]                  invert_mask;
        logic [THR_W-1:0]                   jump_threshold;
        logic [AGE_W-1:0]                   stale_limit_us;
        logic [NUM_OFFSETS-1:0][OFF_W-1:0]  offset;
    } t_cfg;

    typedef struct packed {
        logic                   valid;
        logic signed [Q_W-1:0]  position;
        logic signed [Q_W-1:0]  velocity;
        logic signed [Q_W-1:0]  torque;
    } t_held;

    typedef struct packed {
        logic hold_we;
        logic bias_we;
        logic bias_set;
    } t_upd;

    function automatic logic signed [Q_W-1:0] lim_low(input logic [JOINT_W-1:0] j);
        logic signed [Q_W-1:0] v;
        unique case (j)
            3'd0:    v = -20'sd17157;
            3'd1:    v = 20'sd0;
            3'd2:    v = -20'sd12288;
            3'd3:    v = -20'sd8192;
            3'd4:    v = -20'sd12868;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [Q_W-1:0] lim_high(input logic [JOINT_W-1:0] j);
        logic signed [Q_W-1:0] v;
        unique case (j)
            3'd0:    v = 20'sd17157;
            3'd1:    v = 20'sd14336;
            3'd2:    v = 20'sd614;
            3'd3:    v = 20'sd6431;
            3'd4:    v = 20'sd12868;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

[sv/jfq_regs.sv]
// ----------------------------------------------------------------------------
// Joint feedback qualifier configuration registers
// APB-style register file holding the sign mask, thresholds and zero offsets.
// ----------------------------------------------------------------------------
module jfq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jfq_pkg::ADDR_W-1:0]    paddr,
    input  logic [jfq_pkg::DATA_W-1:0]    pwdata,
    output logic [jfq_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output jfq_pkg::t_cfg                 o_cfg
);

    jfq_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_mask    <= jfq_pkg::RST_INVERT;
            r_cfg.jump_threshold <= jfq_pkg::RST_THR;
            r_cfg.stale_limit_us <= jfq_pkg::RST_STALE;
            r_cfg.offset[0]      <= jfq_pkg::RST_OFF_A;
            r_cfg.offset[1]      <= jfq_pkg::RST_OFF_B;
            r_cfg.offset[2]      <= jfq_pkg::RST_OFF_C;
            r_cfg.offset[3]      <= jfq_pkg::RST_OFF_D;
            r_cfg.offset[4]      <= jfq_pkg::RST_OFF_E;
        end else if (wr_en) begin
            unique case (idx)
                jfq_pkg::REG_INVERT:   r_cfg.invert_mask    <= pwdata[jfq_pkg::MASK_W-1:0];
                jfq_pkg::REG_JUMP_THR: r_cfg.jump_threshold <= pwdata[jfq_pkg::THR_W-1:0];
                jfq_pkg::REG_STALE:    r_cfg.stale_limit_us <= pwdata[jfq_pkg::AGE_W-1:0];
                jfq_pkg::REG_OFF_A:    r_cfg.offset[0]      <= pwdata[jfq_pkg::OFF_W-1:0];
                jfq_pkg::REG_OFF_B:    r_cfg.offset[1]      <= pwdata[jfq_pkg::OFF_W-1:0];
                jfq_pkg::REG_OFF_C:    r_cfg.offset[2]      <= pwdata[jfq_pkg::OFF_W-1:0];
                jfq_pkg::REG_OFF_D:    r_cfg.offset[3]      <= pwdata[jfq_pkg::OFF_W-1:0];
                jfq_pkg::REG_OFF_E:    r_cfg.offset[4]      <= pwdata[jfq_pkg::OFF_W-1:0];
                default:               r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            jfq_pkg::REG_INVERT:   prdata = 32'(r_cfg.invert_mask);
            jfq_pkg::REG_JUMP_THR: prdata = 32'(r_cfg.jump_threshold);
            jfq_pkg::REG_STALE:    prdata = 32'(r_cfg.stale_limit_us);
            jfq_pkg::REG_OFF_A:    prdata = 32'(r_cfg.offset[0]);
            jfq_pkg::REG_OFF_B:    prdata = 32'(r_cfg.offset[1]);
            jfq_pkg::REG_OFF_C:    prdata = 32'(r_cfg.offset[2]);
            jfq_pkg::REG_OFF_D:    prdata = 32'(r_cfg.offset[3]);
            jfq_pkg::REG_OFF_E:    prdata = 32'(r_cfg.offset[4]);
            default:               prdata = '0;
        endcase
    end

endmodule

[sv/jfq_core.sv]
// ----------------------------------------------------------------------------
// Joint feedback qualifier datapath
// Maps one sample, checks age, finiteness and position jump, and selects
// the new joint state, the held state, or zeros for an out-of-range joint.
// ----------------------------------------------------------------------------
module jfq_core (
    input  jfq_pkg::t_in    i_item,
    input  logic            i_in_range,
    input  jfq_pkg::t_cfg   i_cfg,
    input  jfq_pkg::t_held  i_held,
    input  logic            i_bias_decided,
    input  logic            i_bias_set,
    output jfq_pkg::t_out   o_res,
    output jfq_pkg::t_upd   o_upd
);

    logic [7:0]            mask_ext;
    logic                  inv;
    logic signed [13:0]    off;
    logic signed [20:0]    rp_s;
    logic signed [20:0]    rp_n;
    logic signed [21:0]    base;
    logic signed [21:0]    q_pre;
    logic signed [21:0]    q_lo;
    logic signed [21:0]    q_hi;
    logic signed [21:0]    q_clamp;
    logic signed [19:0]    q;
    logic signed [19:0]    lo;
    logic signed [19:0]    hi;
    logic signed [19:0]    dq;
    logic signed [19:0]    tau;
    logic signed [20:0]    diff;
    logic [20:0]           diff_abs;
    logic [19:0]           age_lim;
    logic                  is_bias_joint;
    logic                  deciding;
    logic                  new_bias;
    logic                  eff_bias;
    logic                  stale;
    logic                  jump;

    assign mask_ext      = {3'b000, i_cfg.invert_mask};
    assign inv           = mask_ext[i_item.joint];
    assign is_bias_joint = (i_item.joint == jfq_pkg::BIAS_JOINT);

    always_comb begin
        if (i_item.joint < 3'(jfq_pkg::NUM_OFFSETS)) begin
            off = $signed(i_cfg.offset[i_item.joint]);
        end else begin
            off = '0;
        end
    end

    assign rp_s = {i_item.raw_position[19], i_item.raw_position};
    assign rp_n = -rp_s;
    assign base = inv ? ({rp_n[20], rp_n} - {{8{off[13]}}, off})
                      : ({rp_s[20], rp_s} - {{8{off[13]}}, off});

    assign deciding = i_in_range & is_bias_joint & i_item.has_sample & ~i_bias_decided;
    assign new_bias = i_item.sample_finite
                    & (base >= $signed({{2{jfq_pkg::J1_LOW[19]}}, jfq_pkg::J1_LOW}
                                       - {2'b00, jfq_pkg::FULL_TURN}))
                    & (base <= $signed({{2{jfq_pkg::J1_HIGH[19]}}, jfq_pkg::J1_HIGH}
                                       - {2'b00, jfq_pkg::FULL_TURN}));
    assign eff_bias = deciding ? new_bias : i_bias_set;

    assign q_pre = (is_bias_joint && eff_bias) ? base + {2'b00, jfq_pkg::FULL_TURN} : base;
    assign lo    = jfq_pkg::lim_low(i_item.joint);
    assign hi    = jfq_pkg::lim_high(i_item.joint);
    assign q_lo  = {{2{lo[19]}}, lo};
    assign q_hi  = {{2{hi[19]}}, hi};

    always_comb begin
        if (q_pre < q_lo) begin
            q_clamp = q_lo;
        end else if (q_pre > q_hi) begin
            q_clamp = q_hi;
        end else begin
            q_clamp = q_pre;
        end
    end
    assign q = q_clamp[19:0];

    always_comb begin
        if (!inv) begin
            dq = i_item.raw_velocity;
        end else if (i_item.raw_velocity == jfq_pkg::Q_MIN) begin
            dq = jfq_pkg::Q_MAX;
        end else begin
            dq = -i_item.raw_velocity;
        end
        if (!inv) begin
            tau = i_item.raw_torque;
        end else if (i_item.raw_torque == jfq_pkg::Q_MIN) begin
            tau = jfq_pkg::Q_MAX;
        end else begin
            tau = -i_item.raw_torque;
        end
    end

    assign diff     = {i_held.position[19], i_held.position} - {q[19], q};
    assign diff_abs = diff[20] ? 21'(-diff) : 21'(diff);
    assign jump     = i_held.valid & (diff_abs > {2'b00, i_cfg.jump_threshold});

    assign age_lim = (i_cfg.stale_limit_us < jfq_pkg::MIN_STALE) ? jfq_pkg::MIN_STALE
                                                                  : i_cfg.stale_limit_us;
    assign stale   = ~i_item.has_sample | (i_item.age_us > age_lim);

    always_comb begin
        o_res.position  = i_held.position;
        o_res.velocity  = i_held.velocity;
        o_res.torque    = i_held.torque;
        o_res.valid_res = 1'b0;
        o_res.status    = jfq_pkg::ST_STALE;
        o_upd.hold_we   = 1'b0;
        o_upd.bias_we   = deciding;
        o_upd.bias_set  = new_bias;
        priority if (!i_in_range) begin
            o_res.position = '0;
            o_res.velocity = '0;
            o_res.torque   = '0;
        end else if (stale) begin
            o_res.status = jfq_pkg::ST_STALE;
        end else if (!i_item.sample_finite) begin
            o_res.status = jfq_pkg::ST_NONFINITE;
        end else if (jump) begin
            o_res.status = jfq_pkg::ST_JUMP;
        end else begin
            o_res.position  = q;
            o_res.velocity  = dq;
            o_res.torque    = tau;
            o_res.valid_res = 1'b1;
            o_res.status    = jfq_pkg::ST_OK;
            o_upd.hold_we   = 1'b1;
        end
    end

endmodule

[sv/joint_feedback_qualifier.sv]
// ----------------------------------------------------------------------------
// Joint feedback qualifier
// A transfer passes the input register, then the result register;
// throughput one transfer per cycle while the receiver takes results, set by the
// single mapping and jump-check pass between the two registers.
// Reset clears held valid bits, the turn bias decision, the handshake state
// and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module joint_feedback_qualifier #(
    parameter int NUM_JOINTS = jfq_pkg::NUM_JOINTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  jfq_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output jfq_pkg::t_out                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jfq_pkg::ADDR_W-1:0]    paddr,
    input  logic [jfq_pkg::DATA_W-1:0]    pwdata,
    output logic [jfq_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic [jfq_pkg::JOINT_W-1:0] JOINT_CNT = jfq_pkg::JOINT_W'(NUM_JOINTS);

    jfq_pkg::t_cfg          cfg;
    jfq_pkg::t_in           r_in;
    logic                   r_in_valid;
    jfq_pkg::t_out          r_out;
    logic                   r_out_valid;
    logic                   r_bias_decided;
    logic                   r_bias_set;
    logic [NUM_JOINTS-1:0]  r_held_valid;
    logic signed [19:0]     r_held_pos [NUM_JOINTS];
    logic signed [19:0]     r_held_vel [NUM_JOINTS];
    logic signed [19:0]     r_held_tau [NUM_JOINTS];

    jfq_pkg::t_held         held;
    jfq_pkg::t_out          res;
    jfq_pkg::t_upd          upd;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic                   fire;

    jfq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign fire       = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | fire;
    assign in_range   = (r_in.joint < JOINT_CNT);
    assign idx        = r_in.joint[IDX_W-1:0];

    always_comb begin
        if (in_range && r_held_valid[idx]) begin
            held.valid    = 1'b1;
            held.position = r_held_pos[idx];
            held.velocity = r_held_vel[idx];
            held.torque   = r_held_tau[idx];
        end else begin
            held = '0;
        end
    end

    jfq_core u_core (
        .i_item         (r_in),
        .i_in_range     (in_range),
        .i_cfg          (cfg),
        .i_held         (held),
        .i_bias_decided (r_bias_decided),
        .i_bias_set     (r_bias_set),
        .o_res          (res),
        .o_upd          (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_decided <= 1'b0;
            r_bias_set     <= 1'b0;
            r_held_valid   <= '0;
        end else if (fire) begin
            if (upd.bias_we) begin
                r_bias_decided <= 1'b1;
                r_bias_set     <= upd.bias_set;
            end
            if (upd.hold_we) begin
                r_held_valid[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && upd.hold_we) begin
            r_held_pos[idx] <= res.position;
            r_held_vel[idx] <= res.velocity;
            r_held_tau[idx] <= res.torque;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joint feedback qualifier testbench
// Drives feedback samples through the valid/ready input channel and checks
// every published joint state against an in-bench tracker of the held state,
// the turn bias decision and the register settings. The run walks through
// several register settings written over the APB port. Both channels idle at
// random, and one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 305;
    localparam int NUM_SETTINGS  = 6;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 300;

    class joint_state_tracker;
        logic [jfq_pkg::MASK_W-1:0] invert_mask;
        int unsigned       jump_thr;
        int unsigned       stale_limit;
        int                offset[jfq_pkg::NUM_JOINTS];
        int                lim_lo[jfq_pkg::NUM_JOINTS];
        int                lim_hi[jfq_pkg::NUM_JOINTS];
        int                held_pos[jfq_pkg::NUM_JOINTS];
        int                held_vel[jfq_pkg::NUM_JOINTS];
        int                held_trq[jfq_pkg::NUM_JOINTS];
        bit                held_ok[jfq_pkg::NUM_JOINTS];
        bit                bias_on;
        bit                bias_decided;
        jfq_pkg::t_out     pending_states[$];
        int                status_count[4];
        int                n_samples;
        int                n_checked;
        int                errors;

        function new();
            invert_mask = jfq_pkg::RST_INVERT;
            jump_thr    = jfq_pkg::RST_THR;
            stale_limit = jfq_pkg::RST_STALE;
            offset      = '{-82, 573, 410, 1479, 0};
            lim_lo      = '{-17157, 0, -12288, -8192, -12868};
            lim_hi      = '{17157, 14336, 614, 6431, 12868};
            held_pos    = '{default: 0};
            held_vel    = '{default: 0};
            held_trq    = '{default: 0};
            held_ok     = '{default: 0};
            status_count = '{default: 0};
            bias_on      = 0;
            bias_decided = 0;
            n_samples    = 0;
            n_checked    = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [jfq_pkg::DATA_W-1:0] value);
            case (idx)
                jfq_pkg::REG_INVERT:   invert_mask = value[jfq_pkg::MASK_W-1:0];
                jfq_pkg::REG_JUMP_THR: jump_thr = value[jfq_pkg::THR_W-1:0];
                jfq_pkg::REG_STALE:    stale_limit = value[jfq_pkg::AGE_W-1:0];
                default: offset[idx - jfq_pkg::REG_OFF_A] = $signed(value[jfq_pkg::OFF_W-1:0]);
            endcase
        endfunction

        function int sat_q(int v);
            if (v > jfq_pkg::Q_MAX) return jfq_pkg::Q_MAX;
            if (v < jfq_pkg::Q_MIN) return jfq_pkg::Q_MIN;
            return v;
        endfunction

        function void take_sample(jfq_pkg::t_in s);
            jfq_pkg::t_out r;
            int          j, rp, rv, rt, q, base, diff;
            int unsigned lim;
            r = '0;
            r.status = jfq_pkg::ST_STALE;
            j = s.joint;
            n_samples++;
            if (j < jfq_pkg::NUM_JOINTS) begin
                rp = s.raw_position;
                rv = s.raw_velocity;
                rt = s.raw_torque;
                if (invert_mask[j]) begin
                    rp = -rp;
                    rv = -rv;
                    rt = -rt;
                end
                // The first present sample of the bias joint fixes the turn bias.
                if (j == jfq_pkg::BIAS_JOINT && s.has_sample && !bias_decided) begin
                    base = rp - offset[j];
                    bias_decided = 1;
                    bias_on = s.sample_finite
                              && !(base >= jfq_pkg::J1_LOW && base <= jfq_pkg::J1_HIGH)
                              && base >= jfq_pkg::J1_LOW - jfq_pkg::FULL_TURN
                              && base <= jfq_pkg::J1_HIGH - jfq_pkg::FULL_TURN;
                end
                lim = (stale_limit < jfq_pkg::MIN_STALE) ? jfq_pkg::MIN_STALE : stale_limit;
                r.position = held_pos[j];
                r.velocity = held_vel[j];
                r.torque   = held_trq[j];
                if (!s.has_sample || s.age_us > lim) begin
                    r.status = jfq_pkg::ST_STALE;
                end else if (!s.sample_finite) begin
                    r.status = jfq_pkg::ST_NONFINITE;
                end else begin
                    q = rp - offset[j];
                    if (j == jfq_pkg::BIAS_JOINT && bias_on) q += jfq_pkg::FULL_TURN;
                    if (q < lim_lo[j]) q = lim_lo[j];
                    if (q > lim_hi[j]) q = lim_hi[j];
                    diff = held_pos[j] - q;
                    if (diff < 0) diff = -diff;
                    if (held_ok[j] && diff > jump_thr) begin
                        r.status = jfq_pkg::ST_JUMP;
                    end else begin
                        held_pos[j] = q;
                        held_vel[j] = sat_q(rv);
                        held_trq[j] = sat_q(rt);
                        held_ok[j]  = 1;
                        r.position  = held_pos[j];
                        r.velocity  = held_vel[j];
                        r.torque    = held_trq[j];
                        r.valid_res = 1'b1;
                        r.status    = jfq_pkg::ST_OK;
                    end
                end
            end
            status_count[r.status]++;
            pending_states = {pending_states, r};
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_published(jfq_pkg::t_out got);
            jfq_pkg::t_out want;
            if (pending_states.size() == 0) begin
                $error("Result transfer with no sample outstanding");
                errors++;
                return;
            end
            want = pending_states.pop_front();
            n_checked++;
            compare_field("position", want.position, got.position);
            compare_field("velocity", want.velocity, got.velocity);
            compare_field("torque", want.torque, got.torque);
            compare_field("valid_res", want.valid_res, got.valid_res);
            compare_field("status", want.status, got.status);
        endfunction

        function int pending();
            return pending_states.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    jfq_pkg::t_in                i_in_data = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    jfq_pkg::t_out               o_out_data;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [jfq_pkg::ADDR_W-1:0]  paddr = '0;
    logic [jfq_pkg::DATA_W-1:0]  pwdata = '0;
    logic [jfq_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    joint_state_tracker tracker;
    bit                 reset_done = 0;
    int                 tx_quiet = 0;
    int                 rx_quiet = 0;

    joint_feedback_qualifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) quiet = $urandom_range(30, 80);
        return $urandom_range(0, 10);
    endfunction

    function automatic logic signed [jfq_pkg::Q_W-1:0] wide_value();
        case ($urandom_range(0, 5))
            0:       return jfq_pkg::Q_MIN;
            1:       return jfq_pkg::Q_MAX;
            default: return jfq_pkg::Q_W'($urandom);
        endcase
    endfunction

    function automatic jfq_pkg::t_in sample(int joint, bit has, int unsigned age, bit fin,
                                            int p, int v, int t);
        jfq_pkg::t_in x;
        x.joint         = jfq_pkg::JOINT_W'(joint);
        x.has_sample    = has;
        x.age_us        = jfq_pkg::AGE_W'(age);
        x.sample_finite = fin;
        x.raw_position  = jfq_pkg::Q_W'(p);
        x.raw_velocity  = jfq_pkg::Q_W'(v);
        x.raw_torque    = jfq_pkg::Q_W'(t);
        return x;
    endfunction

    // Most positions land near the held position of the joint, so that
    // the jump check both passes and fails for the smaller thresholds.
    function automatic jfq_pkg::t_in random_item();
        jfq_pkg::t_in x;
        int          j, span, q, base, raw;
        int unsigned lim;
        lim = (tracker.stale_limit < jfq_pkg::MIN_STALE) ? jfq_pkg::MIN_STALE
                                                         : tracker.stale_limit;
        if ($urandom_range(0, 19) == 0)
            x.joint = jfq_pkg::JOINT_W'($urandom_range(jfq_pkg::NUM_JOINTS, 7));
        else
            x.joint = jfq_pkg::JOINT_W'($urandom_range(0, jfq_pkg::NUM_JOINTS - 1));
        x.has_sample    = ($urandom_range(0, 24) != 0);
        x.sample_finite = ($urandom_range(0, 19) != 0);
        case ($urandom_range(0, 9))
            0:       x.age_us = jfq_pkg::AGE_W'($urandom);
            1:       x.age_us = jfq_pkg::AGE_W'(lim);
            2:       x.age_us = jfq_pkg::AGE_W'(lim + 1);
            default: x.age_us = jfq_pkg::AGE_W'($urandom_range(0, lim));
        endcase
        x.raw_velocity = wide_value();
        x.raw_torque   = wide_value();
        j = (x.joint < jfq_pkg::NUM_JOINTS) ? int'(x.joint) : 0;
        if ($urandom_range(0, 9) == 0) begin
            raw = wide_value();
        end else begin
            span = tracker.jump_thr + tracker.jump_thr / 4 + 2;
            if (span > 30000) span = 30000;
            q = tracker.held_pos[j] + int'($urandom_range(0, 2 * span)) - span;
            base = (j == jfq_pkg::BIAS_JOINT && tracker.bias_on) ? q - jfq_pkg::FULL_TURN : q;
            raw = base + tracker.offset[j];
            if (tracker.invert_mask[j]) raw = -raw;
            if (raw > jfq_pkg::Q_MAX) raw = jfq_pkg::Q_MAX;
            if (raw < jfq_pkg::Q_MIN) raw = jfq_pkg::Q_MIN;
        end
        x.raw_position = jfq_pkg::Q_W'(raw);
        return x;
    endfunction

    task automatic send_item(jfq_pkg::t_in x);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_sample(x);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [jfq_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(int setting);
        logic [jfq_pkg::DATA_W-1:0] v[8];
        int                k;
        case (setting)
            1: begin
                v[jfq_pkg::REG_INVERT]   = 32'd31;
                v[jfq_pkg::REG_JUMP_THR] = 32'd524287;
                v[jfq_pkg::REG_STALE]    = 32'd1048575;
                for (k = 0; k < jfq_pkg::NUM_OFFSETS; k++)
                    v[jfq_pkg::REG_OFF_A + k] = 32'd8191;
            end
            2: begin
                v[jfq_pkg::REG_INVERT]   = $urandom_range(0, 31);
                v[jfq_pkg::REG_JUMP_THR] = 32'd0;
                v[jfq_pkg::REG_STALE]    = 32'd10000;
                for (k = 0; k < jfq_pkg::NUM_OFFSETS; k++)
                    v[jfq_pkg::REG_OFF_A + k] = 32'h2000;
            end
            3: begin
                v[jfq_pkg::REG_INVERT]   = 32'b01010;
                v[jfq_pkg::REG_JUMP_THR] = 32'd2000;
                v[jfq_pkg::REG_STALE]    = 32'd5000;
                for (k = 0; k < jfq_pkg::NUM_OFFSETS; k++)
                    v[jfq_pkg::REG_OFF_A + k] = $urandom_range(0, 16383);
            end
            4: begin
                v[jfq_pkg::REG_INVERT]   = $urandom_range(0, 31);
                v[jfq_pkg::REG_JUMP_THR] = ($urandom_range(0, 3) == 0)
                                           ? $urandom_range(0, 524287)
                                           : $urandom_range(0, 600);
                v[jfq_pkg::REG_STALE]    = $urandom_range(0, 1048575);
                for (k = 0; k < jfq_pkg::NUM_OFFSETS; k++)
                    v[jfq_pkg::REG_OFF_A + k] = $urandom_range(0, 16383);
            end
            default: begin
                v[jfq_pkg::REG_INVERT]   = 32'(jfq_pkg::RST_INVERT);
                v[jfq_pkg::REG_JUMP_THR] = 32'(jfq_pkg::RST_THR);
                v[jfq_pkg::REG_STALE]    = 32'(jfq_pkg::RST_STALE);
                v[jfq_pkg::REG_OFF_A]    = 32'(jfq_pkg::RST_OFF_A);
                v[jfq_pkg::REG_OFF_B]    = 32'(jfq_pkg::RST_OFF_B);
                v[jfq_pkg::REG_OFF_C]    = 32'(jfq_pkg::RST_OFF_C);
                v[jfq_pkg::REG_OFF_D]    = 32'(jfq_pkg::RST_OFF_D);
                v[jfq_pkg::REG_OFF_E]    = 32'(jfq_pkg::RST_OFF_E);
            end
        endcase
        for (k = 0; k < 8; k++) apb_write(3'(k), v[k]);
    endtask

    task automatic run_directed(int setting);
        int b;
        case (setting)
            0: begin
                send_item(sample(jfq_pkg::BIAS_JOINT, 0, 0, 1, 0, 0, 0));
                case ($urandom_range(0, 7))
                    0:       b = 5000;
                    1:       b = -20000;
                    2:       b = -5000;
                    3:       b = jfq_pkg::J1_HIGH;
                    4:       b = jfq_pkg::J1_LOW - jfq_pkg::FULL_TURN;
                    5:       b = jfq_pkg::J1_HIGH - jfq_pkg::FULL_TURN;
                    6:       b = jfq_pkg::J1_HIGH - jfq_pkg::FULL_TURN + 1;
                    default: b = jfq_pkg::J1_LOW - jfq_pkg::FULL_TURN - 1;
                endcase
                send_item(sample(jfq_pkg::BIAS_JOINT, 1, $urandom_range(0, 1048575),
                                 $urandom_range(0, 3) != 0,
                                 b + tracker.offset[jfq_pkg::BIAS_JOINT], 77, -77));
                send_item(sample(0, 1, 50000, 1, 0, 100, -100));
                send_item(sample(0, 1, 50001, 1, 0, 5, 5));
                send_item(sample(0, 0, 0, 1, 0, 5, 5));
                send_item(sample(0, 1, 0, 0, 0, 5, 5));
                send_item(sample(0, 1, 0, 1, 500, 5, 5));
                send_item(sample(0, 1, 0, 1, 123, 200, 300));
                send_item(sample(0, 1, 0, 1, 247, 5, 5));
                send_item(sample(2, 1, 0, 0, 0, 5, 5));
                send_item(sample(2, 1, 0, 1, jfq_pkg::Q_MAX, jfq_pkg::Q_MAX, jfq_pkg::Q_MIN));
                send_item(sample(2, 1, 0, 1, jfq_pkg::Q_MIN, 1, 1));
                send_item(sample(3, 1, 0, 1, jfq_pkg::Q_MIN, jfq_pkg::Q_MIN, jfq_pkg::Q_MAX));
                send_item(sample(4, 1, 1048575, 1, 0, 9, 9));
                send_item(sample(4, 1, 0, 1, jfq_pkg::Q_MAX, jfq_pkg::Q_MAX, jfq_pkg::Q_MIN));
                send_item(sample(5, 1, 0, 1, 10, 10, 10));
                send_item(sample(6, 0, 1048575, 0, jfq_pkg::Q_MIN, jfq_pkg::Q_MIN,
                                 jfq_pkg::Q_MIN));
                send_item(sample(7, 1, 0, 1, jfq_pkg::Q_MAX, jfq_pkg::Q_MAX, jfq_pkg::Q_MAX));
            end
            1: begin
                send_item(sample(3, 1, 0, 1, 100, jfq_pkg::Q_MIN, jfq_pkg::Q_MIN));
                send_item(sample(4, 1, 0, 1, 0, jfq_pkg::Q_MIN, jfq_pkg::Q_MAX));
                send_item(sample(jfq_pkg::BIAS_JOINT, 1, 0, 1, -5000, 3, 3));
            end
            3: begin
                send_item(sample(0, 1, 5001, 1, 0, 1, 1));
                send_item(sample(0, 1, 10000, 1, 0, 2, 2));
                send_item(sample(0, 1, 10001, 1, 0, 3, 3));
            end
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int setting;
        int k;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1;
        for (setting = 0; setting < NUM_SETTINGS; setting++) begin
            if (setting > 0) begin
                wait_idle();
                configure(setting);
            end
            run_directed(setting);
            for (k = 0; k < ITEMS_PER_SET; k++) send_item(random_item());
        end
        wait_idle();
        $display("Checked %0d results for %0d samples over %0d register settings.",
                 tracker.n_checked, tracker.n_samples, NUM_SETTINGS);
        $display("Accepted %0d, stale or absent %0d, not finite %0d, jump rejected %0d.",
                 tracker.status_count[jfq_pkg::ST_OK],
                 tracker.status_count[jfq_pkg::ST_STALE],
                 tracker.status_count[jfq_pkg::ST_NONFINITE],
                 tracker.status_count[jfq_pkg::ST_JUMP]);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        int got_count;
        got_count = 0;
        wait (reset_done);
        forever begin
            // One long stall lets the block fill up and hold off the sender.
            gap = (got_count == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_quiet);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            tracker.check_published(o_out_data);
            got_count++;
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[joint_feedback_qualifier.f]
sv/jfq_pkg.sv
sv/jfq_regs.sv
sv/jfq_core.sv
sv/joint_feedback_qualifier.sv
dv/testbench.sv
